// ===== rtl/core/zcgs_pkg.sv =====
// Shared types, constants and threshold tables for the Gaussian sampler.
package zcgs_pkg;

  localparam int TableEntriesDef = 43;
  localparam int SignBitsDef     = 8;
  localparam int RomRows         = 43;

  localparam logic [3:0] PH_SIGN  = 4'd0;
  localparam logic [3:0] PH_WORD  = 4'd1;
  localparam logic [3:0] PH_BYTE0 = 4'd2;
  localparam logic [3:0] PH_BYTE1 = 4'd3;
  localparam logic [3:0] PH_BYTE2 = 4'd4;
  localparam logic [3:0] PH_BYTE3 = 4'd5;
  localparam logic [3:0] PH_CMP   = 4'd6;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  typedef struct packed {
    logic step;    // input beat taken
    logic walk;    // threshold walk running
    logic finish;  // last threshold this cycle
  } zcgs_cmd_t;

  typedef struct packed {
    logic walk_needed;
    logic walk_last;
  } zcgs_sts_t;

  function automatic logic [95:0] rcdt_entry(input logic [5:0] idx);
    logic [95:0] v;
    case (idx)
      6'd0:  v = 96'hce503fb8_2bf9fc6b_88b900fb;
      6'd1:  v = 96'h9e65c9dd_51e6535e_46db7bdf;
      6'd2:  v = 96'h736c8f43_7bf6d15d_822b6b4b;
      6'd3:  v = 96'h4f94bfc5_0a8f7aee_d5a9d95e;
      6'd4:  v = 96'h33c73983_b76a6d03_fce5c221;
      6'd5:  v = 96'h1fb8c3b4_d77825e8_5c8a9f2f;
      6'd6:  v = 96'h124423c9_c9d3367e_8155778f;
      6'd7:  v = 96'h09def8d6_0ffc3c9f_e291c7fe;
      6'd8:  v = 96'h04ffeedb_a2661cd7_057b4a4f;
      6'd9:  v = 96'h025f0053_839e514a_098c7c08;
      6'd10: v = 96'h010d4aaf_5eccd9e6_fe956d82;
      6'd11: v = 96'h006fad4d_c98a463c_153db316;
      6'd12: v = 96'h002b43da_043be9c4_a3cf5e51;
      6'd13: v = 96'h000fa65d_2de92b55_0059f8d0;
      6'd14: v = 96'h00054875_70288c23_c20db91f;
      6'd15: v = 96'h0001a9eb_320acc2c_8f6199b4;
      6'd16: v = 96'h00007d16_2aad04bd_ccdcfcdf;
      6'd17: v = 96'h0000223f_be857857_1acf4e95;
      6'd18: v = 96'h000008bd_84aed6d2_fb61f525;
      6'd19: v = 96'h00000214_185c3df1_8050062c;
      6'd20: v = 96'h00000075_e36133e2_8ce91cc5;
      6'd21: v = 96'h00000018_545de7c6_8a9820ce;
      6'd22: v = 96'h00000004_ad2a532a_f7fa81d7;
      6'd23: v = 96'h00000000_d648da3f_ad547ca0;
      6'd24: v = 96'h00000000_23b6a4bf_33e40e56;
      6'd25: v = 96'h00000000_058aa1c6_7188ac8f;
      6'd26: v = 96'h00000000_00cceb4e_86ca6c0e;
      6'd27: v = 96'h00000000_001b8da0_7d1db494;
      6'd28: v = 96'h00000000_000372c4_09ac00bf;
      6'd29: v = 96'h00000000_000066d2_b972999b;
      6'd30: v = 96'h00000000_00000b25_636b064c;
      6'd31: v = 96'h00000000_0000011f_d6ede1ad;
      6'd32: v = 96'h00000000_0000001b_04fc46a2;
      6'd33: v = 96'h00000000_00000002_5c2b98f5;
      6'd34: v = 96'h00000000_00000000_311a1c8e;
      6'd35: v = 96'h00000000_00000000_03b683de;
      6'd36: v = 96'h00000000_00000000_0042df2f;
      6'd37: v = 96'h00000000_00000000_00046081;
      6'd38: v = 96'h00000000_00000000_00004439;
      6'd39: v = 96'h00000000_00000000_000003dc;
      6'd40: v = 96'h00000000_00000000_00000033;
      6'd41: v = 96'h00000000_00000000_00000002;
      default: v = 96'h0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] accept_entry(input logic [5:0] idx);
    logic [63:0] v;
    case (idx)
      6'd0:  v = 64'hf6e0825e7813b817;
      6'd1:  v = 64'he5983fed29e5e463;
      6'd2:  v = 64'hd585b43a287a0623;
      6'd3:  v = 64'hc69330eb1b2149e5;
      6'd4:  v = 64'hb8ac8c3104cb30f1;
      6'd5:  v = 64'habbf059532c294b9;
      6'd6:  v = 64'h9fb92cad9be6c017;
      6'd7:  v = 64'h948ac9969105667d;
      6'd8:  v = 64'h8a24c712027acf95;
      6'd9:  v = 64'h80791e2ed7f1e3c7;
      6'd10: v = 64'h777ac35ce7fb0a54;
      6'd11: v = 64'h6f1d94d4093b73d3;
      6'd12: v = 64'h67564a367fd11037;
      6'd13: v = 64'h601a6558b3ef7946;
      6'd14: v = 64'h59602419a9563867;
      6'd15: v = 64'h531e73391fcf5674;
      6'd16: v = 64'h4d4ce2199adca33f;
      6'd17: v = 64'h47e3975dccfaaa96;
      6'd18: v = 64'h42db46520ad27c13;
      6'd19: v = 64'h3e2d25137dec1ab8;
      6'd20: v = 64'h39d2e367ce820538;
      6'd21: v = 64'h35c6a238e9d2947e;
      6'd22: v = 64'h3202eba968348d11;
      6'd23: v = 64'h2e82abb6e38cbf8f;
      6'd24: v = 64'h2b4129604e8e8dc4;
      6'd25: v = 64'h283a00470f26313f;
      6'd26: v = 64'h25691ac244098095;
      6'd27: v = 64'h22caac5c376dea47;
      6'd28: v = 64'h205b2cb2901ce178;
      6'd29: v = 64'h1e1752b2575244ee;
      6'd30: v = 64'h1bfc102965bbb00a;
      6'd31: v = 64'h1a068da73cff8510;
      6'd32: v = 64'h183426a7be95e626;
      6'd33: v = 64'h16826602942070da;
      6'd34: v = 64'h14ef029a7a3f9c37;
      6'd35: v = 64'h1377dc47f504a7f8;
      6'd36: v = 64'h121af8fb454605be;
      6'd37: v = 64'h10d68211c0a4f1ba;
      6'd38: v = 64'h0fa8c1daf3638445;
      6'd39: v = 64'h0e90214a33a7bdaf;
      6'd40: v = 64'h0d8b25d189a77cf8;
      6'd41: v = 64'h0c986f63081cfdbe;
      default: v = 64'h0bb6b695e41ab500;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/zcgs_ctrl.sv =====
// Controller: accepts beats and sequences the threshold walk.
module zcgs_ctrl
  import zcgs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  zcgs_sts_t sts,
  output zcgs_cmd_t cmd,
  output logic      idle
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle     = 1'b1;
        cmd.step = in_fire;
        if (in_fire && sts.walk_needed) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk   = 1'b1;
        cmd.finish = sts.walk_last;
        if (sts.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> !cmd.step) else $error("beat taken during walk");
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("walk did not end");
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.walk_needed |=> cmd.walk) else $error("walk did not start");
`endif

endmodule

// ===== rtl/core/zcgs_dp.sv =====
// Datapath: sampler state, threshold walk counter and Bernoulli compare.
module zcgs_dp
  import zcgs_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int SIGN_BITS     = SignBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  zcgs_cmd_t   cmd,
  input  logic [63:0] rand_value,
  input  logic        rand_fault,
  output zcgs_sts_t   sts,
  output logic        res_load,
  output logic [1:0]  res_status,
  output logic [6:0]  res_sample,
  output logic        res_want
);

  localparam int KW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  sign_r, sign_nxt;
  logic [2:0]  bidx_r, bidx_nxt;
  logic [63:0] low_r, low_nxt;
  logic [31:0] high_r, high_nxt;
  logic [5:0]  base_r, base_nxt;
  logic [2:0]  cbi_r, cbi_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic [7:0]  byte_v;
  logic [95:0] thr;
  logic        lt;
  logic [5:0]  cnt_fin;
  logic [5:0]  acc_idx;
  logic [63:0] acc_thr;
  logic [7:0]  tb;
  logic [2:0]  bidx_inc;

  assign byte_v   = rand_value[7:0];
  assign thr      = rcdt_entry(6'(k_r));
  assign lt       = {high_r, low_r} < thr;
  assign cnt_fin  = cnt_r + {5'd0, lt};
  assign acc_idx  = (base_r < 6'(RomRows)) ? base_r : 6'(RomRows - 1);
  assign acc_thr  = accept_entry(acc_idx);
  assign tb       = acc_thr[{~cbi_r, 3'b000} +: 8];
  assign bidx_inc = bidx_r + 3'd1;

  assign sts.walk_needed = (phase_r == PH_BYTE3) && !rand_fault;
  assign sts.walk_last   = (k_r == KW'(TABLE_ENTRIES - 1));

  always_comb begin
    phase_nxt  = phase_r;
    sign_nxt   = sign_r;
    bidx_nxt   = bidx_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    base_nxt   = base_r;
    cbi_nxt    = cbi_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    res_load   = 1'b0;
    res_status = ST_MORE;
    res_sample = 7'd0;
    res_want   = 1'b0;
    if (cmd.walk) begin
      k_nxt   = k_r + KW'(1);
      cnt_nxt = cnt_fin;
      if (cmd.finish) begin
        res_load = 1'b1;
        base_nxt = cnt_fin;
        if (!sign_r[bidx_r]) begin
          phase_nxt  = PH_SIGN;
          res_status = ST_READY;
          res_sample = 7'd0 - {1'b0, cnt_fin};
        end else begin
          cbi_nxt   = 3'd0;
          phase_nxt = PH_CMP;
        end
      end
    end else if (cmd.step) begin
      res_load = 1'b1;
      if (rand_fault) begin
        phase_nxt  = PH_SIGN;
        res_status = ST_FAULT;
      end else begin
        case (phase_r)
          PH_WORD: begin
            low_nxt   = rand_value;
            high_nxt  = 32'd0;
            phase_nxt = PH_BYTE0;
          end
          PH_BYTE0, PH_BYTE1, PH_BYTE2: begin
            high_nxt[{phase_r[1:0] - 2'd2, 3'b000} +: 8] = byte_v;
            phase_nxt = phase_r + 4'd1;
          end
          PH_BYTE3: begin
            res_load       = 1'b0;
            high_nxt[31:24] = byte_v;
            k_nxt          = '0;
            cnt_nxt        = 6'd0;
          end
          PH_CMP: begin
            if (byte_v < tb) begin
              phase_nxt  = PH_SIGN;
              res_status = ST_READY;
              res_sample = {1'b0, base_r} + 7'd1;
            end else if (byte_v == tb && cbi_r != 3'd7) begin
              cbi_nxt = cbi_r + 3'd1;
            end else begin
              bidx_nxt = bidx_inc;
              if ({1'b0, bidx_inc} >= 4'(SIGN_BITS) || bidx_inc == 3'd0) begin
                phase_nxt = PH_SIGN;
              end else begin
                phase_nxt = PH_WORD;
                res_want  = 1'b1;
              end
            end
          end
          default: begin
            sign_nxt  = byte_v;
            bidx_nxt  = 3'd0;
            phase_nxt = PH_WORD;
            res_want  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIGN;
      sign_r  <= 8'd0;
      bidx_r  <= 3'd0;
      low_r   <= 64'd0;
      high_r  <= 32'd0;
      base_r  <= 6'd0;
      cbi_r   <= 3'd0;
      k_r     <= '0;
      cnt_r   <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      sign_r  <= sign_nxt;
      bidx_r  <= bidx_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      base_r  <= base_nxt;
      cbi_r   <= cbi_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cmp_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CMP |-> base_r <= 6'(TABLE_ENTRIES))
    else $error("base sample out of range");
  a_word_after_sign: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !rand_fault && phase_r == PH_SIGN |=> phase_r == PH_WORD)
    else $error("sign beat did not advance");
  a_fault_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && rand_fault |=> phase_r == PH_SIGN)
    else $error("fault did not abort");
`endif

endmodule

// ===== rtl/core/zero_centered_gaussian_sampler_top.sv =====
// Top level of the zero-centered discrete Gaussian sampler.
//
//   channel | dir | beat contents
//   in_     | in  | tdata[63:0] random draw, tuser[0] source fault
//   out_    | out | tdata[1:0] status, [8:2] sample, [9] want word
//
// One result beat per input beat. The beat that completes the 96-bit draw
// also starts the serial walk of the threshold table, which stalls the input
// side until it ends. A result waiting in the output register stalls the
// input side. Reset is synchronous, active low, and clears the state.
module zero_centered_gaussian_sampler_top
  import zcgs_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int SIGN_BITS     = SignBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] random_value
  input  logic        in_tuser,   // [0] rng_fault
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [8:2] sample_value, [9] want_word
);

  zcgs_cmd_t  cmd;
  zcgs_sts_t  sts;
  logic       idle;
  logic       in_fire;
  logic       res_load;
  logic [1:0] res_status;
  logic [6:0] res_sample;
  logic       res_want;
  logic       ov_r, ov_nxt;
  logic [9:0] od_r, od_nxt;

  assign in_tready = idle && (!ov_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  zcgs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .cmd     (cmd),
    .idle    (idle)
  );

  zcgs_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SIGN_BITS     (SIGN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rand_value (in_tdata),
    .rand_fault (in_tuser),
    .sts        (sts),
    .res_load   (res_load),
    .res_status (res_status),
    .res_sample (res_sample),
    .res_want   (res_want)
  );

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (res_load) begin
      ov_nxt = 1'b1;
      od_nxt = {res_want, res_sample, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, od_r};

`ifndef SYNTH
  a_beat_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !sts.walk_needed |=> out_tvalid) else $error("missing result");
  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3) else $error("bad status code");
  a_final_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_MORE |-> !out_tdata[9])
    else $error("word requested after final status");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !ov_r || out_tready) else $error("result overwritten");
`endif

endmodule
